// ----- design/rnr_pkg.sv -----
// ----------------------------------------------------------------------------
// rnr_pkg: shared types and constants for the RMS row normalizer
// Field widths, fixed-point formats, sequencer states and command codes.
// ----------------------------------------------------------------------------
package rnr_pkg;

  // Row length limit and the element counter that must hold it
  localparam int MaxHidden = 4096;
  localparam int CntW      = $clog2(MaxHidden + 1);

  // Request and result field widths
  localparam int ActW = 16;  // activation, signed Q4.12
  localparam int WgtW = 16;  // weight, signed Q2.14
  localparam int OutW = 16;  // normalized output, signed Q4.12
  localparam int EpsW = 16;  // epsilon, units of 2^-24

  localparam logic [EpsW-1:0] EpsReset = EpsW'(17);

  // Datapath widths
  localparam int SumW   = 43;  // sum of squares, unsigned Q19.24
  localparam int ProdW  = 31;  // |a| * |b| of two 16-bit operands
  localparam int ScaleW = 32;  // row scale, unsigned Q12.20
  localparam int MagW   = ProdW + ScaleW;  // product times scale
  localparam int MeanW  = 31;  // mean + epsilon stays below 2^31
  localparam int QuoW   = 64;  // floor(2^64 / m)
  localparam int RemW   = 35;  // partial remainder of divide and root
  localparam int UnitW  = RemW + 1;  // shared subtractor operand width

  // Iteration counts of the shared unit
  localparam int MeanSteps  = SumW;
  localparam int RecipSteps = QuoW + 1;
  localparam int RootSteps  = ScaleW;
  localparam int StepW      = $clog2(RecipSteps);

  // Output rounding and saturation
  localparam int RndW     = 64;
  localparam int RndShift = 34;
  localparam int RW       = RndW - RndShift;
  localparam logic [RW-1:0] SatPos = RW'(32767);
  localparam logic [RW-1:0] SatNeg = RW'(32768);

  typedef enum logic {
    CMD_ACC  = 1'b0,
    CMD_NORM = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_ACC,
    ST_DIV_MEAN,
    ST_MEAN_ADD,
    ST_DIV_RECIP,
    ST_ROOT,
    ST_OUT
  } state_e;

endpackage

// ----- design/rms_norm_row.sv -----
// ----------------------------------------------------------------------------
// rms_norm_row: RMS normalization of one row, two passes
// Accumulate requests sum activation squares; the last one of a row derives
// the row scale 1/sqrt(mean + epsilon). Normalize requests then return
// activation * scale * weight, rounded and saturated to Q4.12.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------
//  in       | in_valid_i / in_stall_o   | command, activation, weight,
//           |                           | row_end
//  out      | out_valid_o / out_stall_i | normalized, row_last, error
//  cfg      | cfg_we_i                  | cfg_wdata_i (epsilon)
//
//  An accumulate request passes the states MUL and ACC, a normalize request
//  MUL, SCALE and OUT; the single multiplier is used once per accumulate and
//  twice per normalize.
//  An accumulate request with row_end runs up to three phases on the shared
//  subtractor: 43 divide steps for the mean, 65 for 2^64 / (mean + epsilon)
//  and 32 root steps, one step per cycle; empty or overflowed rows run none.
//  Reset clears the sums, the counter and the scale and loads epsilon = 17.
//  A stalled result sits in the output register; the next request is taken
//  meanwhile and a new normalize result waits in its last state until the
//  output register frees.
//
module rms_norm_row (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic signed [rnr_pkg::ActW-1:0]   activation_i,
  input  logic signed [rnr_pkg::WgtW-1:0]   weight_i,
  input  logic                              row_end_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rnr_pkg::OutW-1:0]   normalized_o,
  output logic                              row_last_o,
  output logic                              error_o,
  // epsilon register
  input  logic                              cfg_we_i,
  input  logic [rnr_pkg::EpsW-1:0]          cfg_wdata_i
);

  rnr_pkg::state_e state_q, state_d;

  // Captured request
  rnr_pkg::cmd_e                     cmd_q;
  logic signed [rnr_pkg::ActW-1:0]   act_q;
  logic signed [rnr_pkg::WgtW-1:0]   wgt_q;
  logic                              row_end_q;

  // Architectural row state
  logic [rnr_pkg::EpsW-1:0]   eps_q;
  logic [rnr_pkg::SumW-1:0]   sum_q, sum_d;      // also the mean quotient
  logic [rnr_pkg::CntW-1:0]   count_q, count_d;
  logic [rnr_pkg::ScaleW-1:0] scale_q, scale_d;  // also the root accumulator
  logic                       scale_valid_q, scale_valid_d;
  logic                       ovf_q, ovf_d;

  // Iteration registers
  logic [rnr_pkg::MeanW-1:0]  m_q, m_d;
  logic [rnr_pkg::QuoW-1:0]   quo_q, quo_d;
  logic [rnr_pkg::RemW-1:0]   rem_q, rem_d;
  logic [rnr_pkg::StepW-1:0]  step_q, step_d;

  // Multiplier result and product sign
  logic [rnr_pkg::MagW-1:0]   mul_q, mul_d;
  logic                       neg_q, neg_d;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic signed [rnr_pkg::OutW-1:0]   out_norm_q, out_norm_d;
  logic                              out_last_q, out_last_d;
  logic                              out_err_q, out_err_d;

  // Shared multiplier
  logic [rnr_pkg::ActW-1:0]   abs_act, abs_wgt;
  logic [rnr_pkg::ProdW-1:0]  mul_a;
  logic [rnr_pkg::ScaleW-1:0] mul_b;
  logic [rnr_pkg::MagW-1:0]   mul_res;

  // Shared subtractor
  logic [rnr_pkg::UnitW-1:0]  sub_a, sub_b;
  logic [rnr_pkg::UnitW:0]    sub_diff;
  logic                       sub_ge;
  logic [rnr_pkg::RemW-1:0]   sub_rem;

  // Accumulate and rounding helpers
  logic [rnr_pkg::SumW-1:0]   sum_add;
  logic [rnr_pkg::CntW-1:0]   count_add;
  logic [rnr_pkg::MeanW-1:0]  m_new;
  logic [rnr_pkg::RndW-1:0]   rnd_sum;
  logic [rnr_pkg::RW-1:0]     rnd_mag, rnd_lim;
  logic                       accept, out_free;

  assign accept   = in_valid_i && (state_q == rnr_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o   = (state_q != rnr_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign normalized_o = out_norm_q;
  assign row_last_o   = out_last_q;
  assign error_o      = out_err_q;

  // Magnitudes; the most negative code becomes 32768 as unsigned
  assign abs_act = act_q[rnr_pkg::ActW-1] ? rnr_pkg::ActW'(-act_q) : rnr_pkg::ActW'(act_q);
  assign abs_wgt = wgt_q[rnr_pkg::WgtW-1] ? rnr_pkg::WgtW'(-wgt_q) : rnr_pkg::WgtW'(wgt_q);

  // First pass: |a|*|a| or |a|*|w|; second pass: product times row scale
  always_comb begin
    if (state_q == rnr_pkg::ST_SCALE) begin
      mul_a = mul_q[rnr_pkg::ProdW-1:0];
      mul_b = scale_q;
    end else begin
      mul_a = rnr_pkg::ProdW'(abs_act);
      mul_b = (cmd_q == rnr_pkg::CMD_ACC) ? rnr_pkg::ScaleW'(abs_act)
                                          : rnr_pkg::ScaleW'(abs_wgt);
    end
  end

  assign mul_res = rnr_pkg::MagW'(mul_a) * rnr_pkg::MagW'(mul_b);

  // Subtractor operands: divide steps shift in one dividend bit, root steps
  // shift in two radicand bits and try 4*root + 1
  always_comb begin
    unique case (state_q)
      rnr_pkg::ST_DIV_MEAN: begin
        sub_a = {rem_q, sum_q[rnr_pkg::SumW-1]};
        sub_b = rnr_pkg::UnitW'(count_q);
      end
      rnr_pkg::ST_DIV_RECIP: begin
        // the dividend 2^64 is a one followed by zeros
        sub_a = {rem_q, (step_q == rnr_pkg::StepW'(rnr_pkg::RecipSteps - 1))};
        sub_b = rnr_pkg::UnitW'(m_q);
      end
      rnr_pkg::ST_ROOT: begin
        sub_a = {rem_q[rnr_pkg::RemW-2:0], quo_q[rnr_pkg::QuoW-1 -: 2]};
        sub_b = rnr_pkg::UnitW'({scale_q, 2'b01});
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[rnr_pkg::UnitW];
  assign sub_rem  = sub_ge ? sub_diff[rnr_pkg::RemW-1:0] : sub_a[rnr_pkg::RemW-1:0];

  assign sum_add   = sum_q + rnr_pkg::SumW'(mul_q[rnr_pkg::ProdW-1:0]);
  assign count_add = count_q + rnr_pkg::CntW'(1);
  assign m_new     = rnr_pkg::MeanW'(sum_q[rnr_pkg::MeanW-1:0]) + rnr_pkg::MeanW'(eps_q);

  // Round to nearest, ties away from zero, on the magnitude; then saturate
  assign rnd_sum = rnr_pkg::RndW'(mul_q) + (rnr_pkg::RndW'(1) << (rnr_pkg::RndShift - 1));
  assign rnd_mag = rnd_sum[rnr_pkg::RndW-1:rnr_pkg::RndShift];

  always_comb begin
    if (neg_q) begin
      rnd_lim = (rnd_mag > rnr_pkg::SatNeg) ? rnr_pkg::SatNeg : rnd_mag;
    end else begin
      rnd_lim = (rnd_mag > rnr_pkg::SatPos) ? rnr_pkg::SatPos : rnd_mag;
    end
  end

  // Sequencer and datapath next state
  always_comb begin
    state_d       = state_q;
    sum_d         = sum_q;
    count_d       = count_q;
    scale_d       = scale_q;
    scale_valid_d = scale_valid_q;
    ovf_d         = ovf_q;
    m_d           = m_q;
    quo_d         = quo_q;
    rem_d         = rem_q;
    step_d        = step_q;
    mul_d         = mul_q;
    neg_d         = neg_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_norm_d    = out_norm_q;
    out_last_d    = out_last_q;
    out_err_d     = out_err_q;

    unique case (state_q)
      rnr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = rnr_pkg::ST_MUL;
        end
      end

      rnr_pkg::ST_MUL: begin
        mul_d   = mul_res;
        neg_d   = act_q[rnr_pkg::ActW-1] ^ wgt_q[rnr_pkg::WgtW-1];
        state_d = (cmd_q == rnr_pkg::CMD_ACC) ? rnr_pkg::ST_ACC : rnr_pkg::ST_SCALE;
      end

      rnr_pkg::ST_SCALE: begin
        mul_d   = mul_res;
        state_d = rnr_pkg::ST_OUT;
      end

      rnr_pkg::ST_ACC: begin
        // drop elements past the row limit and flag the row
        if (count_q >= rnr_pkg::CntW'(rnr_pkg::MaxHidden)) begin
          ovf_d = 1'b1;
        end else begin
          sum_d   = sum_add;
          count_d = count_add;
        end
        state_d = rnr_pkg::ST_IDLE;
        if (row_end_q) begin
          if (ovf_d || (count_d == '0)) begin
            scale_d       = '0;
            scale_valid_d = 1'b0;
            sum_d         = '0;
            count_d       = '0;
            ovf_d         = 1'b0;
          end else begin
            rem_d   = '0;
            step_d  = rnr_pkg::StepW'(rnr_pkg::MeanSteps - 1);
            state_d = rnr_pkg::ST_DIV_MEAN;
          end
        end
      end

      rnr_pkg::ST_DIV_MEAN: begin
        rem_d  = sub_rem;
        sum_d  = {sum_q[rnr_pkg::SumW-2:0], sub_ge};
        step_d = step_q - rnr_pkg::StepW'(1);
        if (step_q == '0) begin
          state_d = rnr_pkg::ST_MEAN_ADD;
        end
      end

      rnr_pkg::ST_MEAN_ADD: begin
        m_d     = m_new;
        sum_d   = '0;
        count_d = '0;
        ovf_d   = 1'b0;
        if (m_new <= rnr_pkg::MeanW'(1)) begin
          // scale saturates when mean + epsilon is 0 or 1
          scale_d       = '1;
          scale_valid_d = 1'b1;
          state_d       = rnr_pkg::ST_IDLE;
        end else begin
          rem_d   = '0;
          quo_d   = '0;
          step_d  = rnr_pkg::StepW'(rnr_pkg::RecipSteps - 1);
          state_d = rnr_pkg::ST_DIV_RECIP;
        end
      end

      rnr_pkg::ST_DIV_RECIP: begin
        rem_d  = sub_rem;
        quo_d  = {quo_q[rnr_pkg::QuoW-2:0], sub_ge};
        step_d = step_q - rnr_pkg::StepW'(1);
        if (step_q == '0) begin
          rem_d         = '0;
          scale_d       = '0;
          scale_valid_d = 1'b0;
          step_d        = rnr_pkg::StepW'(rnr_pkg::RootSteps - 1);
          state_d       = rnr_pkg::ST_ROOT;
        end
      end

      rnr_pkg::ST_ROOT: begin
        rem_d   = sub_rem;
        scale_d = {scale_q[rnr_pkg::ScaleW-2:0], sub_ge};
        quo_d   = {quo_q[rnr_pkg::QuoW-3:0], 2'b00};
        step_d  = step_q - rnr_pkg::StepW'(1);
        if (step_q == '0) begin
          scale_valid_d = 1'b1;
          state_d       = rnr_pkg::ST_IDLE;
        end
      end

      rnr_pkg::ST_OUT: begin
        // hold here until the output register can take the result
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = row_end_q;
          out_err_d   = !scale_valid_q;
          if (!scale_valid_q) begin
            out_norm_d = '0;
          end else if (neg_q) begin
            out_norm_d = rnr_pkg::OutW'(-rnd_lim);
          end else begin
            out_norm_d = rnr_pkg::OutW'(rnd_lim);
          end
          state_d = rnr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rnr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and row state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rnr_pkg::ST_IDLE;
      eps_q         <= rnr_pkg::EpsReset;
      sum_q         <= '0;
      count_q       <= '0;
      scale_q       <= '0;
      scale_valid_q <= 1'b0;
      ovf_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      sum_q         <= sum_d;
      count_q       <= count_d;
      scale_q       <= scale_d;
      scale_valid_q <= scale_valid_d;
      ovf_q         <= ovf_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= rnr_pkg::cmd_e'(command_i);
      act_q     <= activation_i;
      wgt_q     <= weight_i;
      row_end_q <= row_end_i;
    end
    m_q        <= m_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    mul_q      <= mul_d;
    neg_q      <= neg_d;
    out_norm_q <= out_norm_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

endmodule
